>>> rtl/ptrs_pkg.sv
// ----------------------------------------------------------------------------
// ptrs_pkg
// Shared types and constants of the packet-train receive statistics unit.
// ----------------------------------------------------------------------------
package ptrs_pkg;

	localparam int TIME_W = 64;
	localparam logic [29:0] NS_PER_S = 30'd1000000000;
	localparam logic [39:0] RATE_MAX = 40'hFF_FFFF_FFFF;
	localparam logic [47:0] TMO_MAX = 48'hFFFF_FFFF_FFFF;
	localparam logic [15:0] GAP_TOL_RST = 16'd256;
	localparam logic signed [34:0] LAST_PKT_EXTRA = 35'sd12;
	localparam logic [0:0] KIND_PACKET = 1'b0;
	localparam logic [0:0] KIND_TIMEOUT = 1'b1;
	localparam int DIV_W = 80;
	localparam int DIV_CNT_W = 7;

	// Closed train handed from the front end to the back end.
	typedef struct packed {
		logic kind;
		logic [31:0] seq;
		logic [15:0] tlen;
		logic [15:0] got;
		logic [15:0] plen;
		logic [15:0] tol;
		logic [15:0] stale;
		logic [15:0] skip;
		logic [31:0] bytes;
		logic [TIME_W-1:0] delay;
		logic [TIME_W-1:0] span;
	} job_t;

	typedef struct packed {
		logic close_cause;
		logic [31:0] train_seq;
		logic [15:0] drop_fraction;
		logic [63:0] one_way_delay_ns;
		logic [39:0] data_rate;
		logic rate_invalid;
		logic [47:0] next_timeout_ns;
		logic timeout_valid;
		logic [15:0] stale_count;
		logic [15:0] skip_count;
	} result_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_CNT_W-1:0] nsteps;
		logic [63:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

endpackage

>>> rtl/ptrs_front.sv
// ----------------------------------------------------------------------------
// ptrs_front
// Accepts probe events, tracks the expected train and emits a job per close.
// ----------------------------------------------------------------------------
module ptrs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic                       event_kind,
	input  logic [31:0]                seq_number,
	input  logic [15:0]                packet_index,
	input  logic [15:0]                train_length,
	input  logic [15:0]                packet_length,
	input  logic [ptrs_pkg::TIME_W-1:0] send_time_ns,
	input  logic [ptrs_pkg::TIME_W-1:0] recv_time_ns,
	input  logic [15:0]                gap_tol,
	output logic                       job_push,
	output ptrs_pkg::job_t             job
);

	logic [31:0] exp_seq_q, hi_stale_q;
	logic [15:0] cnt_q, first_idx_q, last_idx_q, tlen_q, plen_q, stale_q, skip_q;
	logic [ptrs_pkg::TIME_W-1:0] first_recv_q, first_send_q, last_recv_q;

	logic cnt0, is_exp, is_newer, in_train, is_last, tmo_close;
	logic [15:0] tl1, cnt_inc, f_idx, m_len, m_last, m_first;
	logic [ptrs_pkg::TIME_W-1:0] f_recv, f_send;
	logic signed [16:0] idx_diff;
	logic signed [33:0] bprod;
	logic signed [34:0] bsum;

	assign cnt0      = (cnt_q == 16'd0);
	assign is_exp    = (seq_number == exp_seq_q);
	assign is_newer  = (seq_number > exp_seq_q);
	assign tl1       = train_length - 16'd1;
	assign in_train  = (train_length != 16'd0) && (packet_index < tl1);
	assign is_last   = (train_length != 16'd0) && (packet_index == tl1);
	assign tmo_close = (event_kind == ptrs_pkg::KIND_TIMEOUT) && !cnt0;
	assign cnt_inc   = (cnt_q == 16'hFFFF) ? cnt_q : cnt_q + 16'd1;
	assign f_idx     = cnt0 ? packet_index : first_idx_q;
	assign f_recv    = cnt0 ? recv_time_ns : first_recv_q;
	assign f_send    = cnt0 ? send_time_ns : first_send_q;

	// one multiplier serves both close kinds
	always_comb begin
		if (event_kind == ptrs_pkg::KIND_TIMEOUT) begin
			m_len = plen_q;
			m_last = last_idx_q;
			m_first = first_idx_q;
		end else begin
			m_len = packet_length;
			m_last = packet_index;
			m_first = f_idx;
		end
		idx_diff = $signed({1'b0, m_last}) - $signed({1'b0, m_first});
		bprod = $signed({1'b0, m_len}) * idx_diff;
		bsum = {bprod[33], bprod}
			+ ((event_kind == ptrs_pkg::KIND_TIMEOUT) ? 35'sd0 : ptrs_pkg::LAST_PKT_EXTRA);
	end

	always_comb begin
		job = '0;
		job.seq = exp_seq_q;
		job.tol = gap_tol;
		job.stale = stale_q;
		job.skip = skip_q;
		job.delay = f_recv - f_send;
		job.bytes = bsum[34] ? 32'd0 : bsum[31:0];
		if (event_kind == ptrs_pkg::KIND_TIMEOUT) begin
			job.kind = 1'b1;
			job.tlen = tlen_q;
			job.got = cnt_q;
			job.plen = plen_q;
			job.span = last_recv_q - first_recv_q;
		end else begin
			job.kind = 1'b0;
			job.tlen = train_length;
			job.got = cnt_inc;
			job.plen = packet_length;
			if (cnt0) begin
				job.bytes = {16'd0, packet_length};
				job.span = f_recv - f_send;
			end else begin
				job.span = recv_time_ns - f_recv;
			end
		end
	end

	assign job_push = accept && (tmo_close ||
		((event_kind == ptrs_pkg::KIND_PACKET) && is_exp && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_seq_q <= '0;
			hi_stale_q <= '0;
			cnt_q <= '0;
			first_idx_q <= '0;
			last_idx_q <= '0;
			tlen_q <= 16'd1;
			plen_q <= '0;
			stale_q <= '0;
			skip_q <= '0;
			first_recv_q <= '0;
			first_send_q <= '0;
			last_recv_q <= '0;
		end else if (accept) begin
			if (event_kind == ptrs_pkg::KIND_TIMEOUT) begin
				if (tmo_close) begin
					cnt_q <= '0;
					exp_seq_q <= exp_seq_q + 32'd1;
				end
			end else if (is_exp) begin
				first_idx_q <= f_idx;
				first_recv_q <= f_recv;
				first_send_q <= f_send;
				if (in_train || is_last) begin
					last_recv_q <= recv_time_ns;
					last_idx_q <= packet_index;
					tlen_q <= train_length;
					plen_q <= packet_length;
				end
				if (in_train) begin
					cnt_q <= cnt_inc;
				end else if (is_last) begin
					cnt_q <= '0;
					exp_seq_q <= exp_seq_q + 32'd1;
				end
			end else if (is_newer) begin
				skip_q <= (skip_q == 16'hFFFF) ? skip_q : skip_q + 16'd1;
				exp_seq_q <= exp_seq_q + 32'd1;
				first_recv_q <= recv_time_ns;
				first_idx_q <= packet_index;
				first_send_q <= send_time_ns;
				tlen_q <= train_length;
				plen_q <= packet_length;
			end else begin
				if (hi_stale_q < seq_number)
					stale_q <= (stale_q == 16'hFFFF) ? stale_q : stale_q + 16'd1;
				hi_stale_q <= seq_number;
			end
		end
	end

endmodule

>>> rtl/ptrs_jobq.sv
// ----------------------------------------------------------------------------
// ptrs_jobq
// Two-entry queue of closed trains between front end and back end.
// ----------------------------------------------------------------------------
module ptrs_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ptrs_pkg::job_t wdata,
	input  logic           pop,
	output ptrs_pkg::job_t rdata,
	output logic           full,
	output logic           empty
);

	ptrs_pkg::job_t mem_q [2];
	logic wptr_q, rptr_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wptr_q <= ~wptr_q;
			if (pop)
				rptr_q <= ~rptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

>>> rtl/ptrs_div.sv
// ----------------------------------------------------------------------------
// ptrs_div
// Restoring divider, one quotient bit per cycle, dividend left aligned.
// ----------------------------------------------------------------------------
module ptrs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  ptrs_pkg::div_req_t req,
	output ptrs_pkg::div_rsp_t rsp
);

	logic [ptrs_pkg::DIV_W-1:0] dvd_q, quo_q;
	logic [63:0] rem_q, div_q;
	logic [ptrs_pkg::DIV_CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [64:0] trial, diff;
	logic ge;

	assign trial = {rem_q, dvd_q[ptrs_pkg::DIV_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = (trial >= {1'b0, div_q});

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quotient = quo_q;

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			div_q <= req.divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ptrs_pkg::DIV_W-2:0], 1'b0};
			rem_q <= ge ? diff[63:0] : trial[63:0];
			quo_q <= {quo_q[ptrs_pkg::DIV_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= req.nsteps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule

>>> rtl/ptrs_back.sv
// ----------------------------------------------------------------------------
// ptrs_back
// Works out drop fraction, rate and next timeout of a closed train.
// ----------------------------------------------------------------------------
module ptrs_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                jq_empty,
	input  ptrs_pkg::job_t      jq_data,
	output logic                jq_pop,
	input  logic                pop,
	output logic                out_valid,
	output ptrs_pkg::result_t   result
);

	typedef enum logic [9:0] {
		S_IDLE   = 10'b0000000001,
		S_MUL1   = 10'b0000000010,
		S_DROP   = 10'b0000000100,
		S_RSTART = 10'b0000001000,
		S_RATE   = 10'b0000010000,
		S_MUL2   = 10'b0000100000,
		S_MUL3   = 10'b0001000000,
		S_TSTART = 10'b0010000000,
		S_TDIV   = 10'b0100000000,
		S_OUT    = 10'b1000000000
	} state_t;

	state_t state_q;
	ptrs_pkg::job_t job_q;
	ptrs_pkg::result_t res_q;
	ptrs_pkg::div_req_t dreq;
	ptrs_pkg::div_rsp_t drsp;
	logic out_valid_q;
	logic [61:0] rnum_q, lo_q;
	logic [31:0] t1_q;
	logic [47:0] t2_q;
	logic [45:0] hi_q;
	logic [79:0] num_q;
	logic [15:0] drop_q, diff;
	logic [39:0] rate_q;
	logic bad_q;

	assign diff = (job_q.got < job_q.tlen) ? job_q.tlen - job_q.got : 16'd0;
	assign jq_pop = (state_q == S_IDLE) && !jq_empty && !out_valid_q;
	assign out_valid = out_valid_q;
	assign result = res_q;

	always_comb begin
		dreq = '0;
		unique case (state_q)
			S_MUL1: begin
				dreq.start = (diff != 16'd0);
				dreq.dividend = {diff, 64'd0};
				dreq.nsteps = 7'd32;
				dreq.divisor = {48'd0, job_q.tlen};
			end
			S_RSTART: begin
				dreq.start = (job_q.span != '0);
				dreq.dividend = {2'b00, rnum_q, 16'd0};
				dreq.nsteps = 7'd64;
				dreq.divisor = job_q.span;
			end
			S_TSTART: begin
				dreq.start = 1'b1;
				dreq.dividend = num_q;
				dreq.nsteps = 7'd80;
				dreq.divisor = {16'd0, rate_q, 8'd0};
			end
			default: dreq = '0;
		endcase
	end

	ptrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE:
				if (jq_pop)
					job_q <= jq_data;
			S_MUL1: begin
				rnum_q <= job_q.bytes * ptrs_pkg::NS_PER_S;
				t1_q <= job_q.tol * diff;
				if (diff == 16'd0)
					drop_q <= '0;
			end
			S_DROP:
				if (drsp.done)
					drop_q <= drsp.quotient[15:0];
			S_RSTART: begin
				t2_q <= t1_q * job_q.plen;
				if (job_q.span == '0) begin
					rate_q <= ptrs_pkg::RATE_MAX;
					bad_q <= 1'b1;
					res_q.next_timeout_ns <= '0;
					res_q.timeout_valid <= 1'b0;
				end
			end
			S_RATE:
				if (drsp.done) begin
					bad_q <= 1'b0;
					rate_q <= (drsp.quotient > {40'd0, ptrs_pkg::RATE_MAX}) ?
						ptrs_pkg::RATE_MAX : drsp.quotient[39:0];
				end
			S_MUL2: begin
				lo_q <= t2_q[31:0] * ptrs_pkg::NS_PER_S;
				hi_q <= t2_q[47:32] * ptrs_pkg::NS_PER_S;
				res_q.timeout_valid <= job_q.kind && (rate_q != '0);
				res_q.next_timeout_ns <= '0;
			end
			S_MUL3:
				num_q <= {18'd0, lo_q} + {2'd0, hi_q, 32'd0};
			S_TDIV:
				if (drsp.done)
					res_q.next_timeout_ns <= (drsp.quotient > {32'd0, ptrs_pkg::TMO_MAX}) ?
						ptrs_pkg::TMO_MAX : drsp.quotient[47:0];
			S_OUT: begin
				res_q.close_cause <= job_q.kind;
				res_q.train_seq <= job_q.seq;
				res_q.drop_fraction <= drop_q;
				res_q.one_way_delay_ns <= job_q.delay;
				res_q.data_rate <= rate_q;
				res_q.rate_invalid <= bad_q;
				res_q.stale_count <= job_q.stale;
				res_q.skip_count <= job_q.skip;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && out_valid_q)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE:
					if (jq_pop)
						state_q <= S_MUL1;
				S_MUL1:
					state_q <= (diff != 16'd0) ? S_DROP : S_RSTART;
				S_DROP:
					if (drsp.done)
						state_q <= S_RSTART;
				S_RSTART:
					state_q <= (job_q.span == '0) ? S_OUT : S_RATE;
				S_RATE:
					if (drsp.done)
						state_q <= S_MUL2;
				S_MUL2:
					state_q <= (job_q.kind && rate_q != '0 && diff != 16'd0) ? S_MUL3 : S_OUT;
				S_MUL3:
					state_q <= S_TSTART;
				S_TSTART:
					state_q <= S_TDIV;
				S_TDIV:
					if (drsp.done)
						state_q <= S_OUT;
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/packet_train_receive_stats_unit.sv
// ----------------------------------------------------------------------------
// packet_train_receive_stats_unit
// Receive side of a packet-train probe: per-train loss, delay, rate, timeout.
// ----------------------------------------------------------------------------
// Input events enter through push/full, one per cycle while full is low; an
// event that does not close a train only updates the tracking state.
// Closing events are queued (two entries) for the back end, which divides
// serially through one shared divider, one quotient bit per cycle: the drop
// fraction when packets are missing, then the rate, then for a timeout
// close with a timeout to compute the next timeout. The result then waits
// in the output register: empty is low and pop takes it. While the
// receiver stalls, the back end takes no new job, so closed trains wait in
// the job queue; the front end keeps taking events until that queue fills,
// then full is raised.
// Reset clears the tracking state and counters; gap_tolerance returns to
// 1.0 (Q8.8). The APB port holds gap_tolerance at address 0; no clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module packet_train_receive_stats_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        push,
	output logic        full,
	input  logic        event_kind,
	input  logic [31:0] seq_number,
	input  logic [15:0] packet_index,
	input  logic [15:0] train_length,
	input  logic [15:0] packet_length,
	input  logic [63:0] send_time_ns,
	input  logic [63:0] recv_time_ns,
	output logic        empty,
	input  logic        pop,
	output logic        close_cause,
	output logic [31:0] train_seq,
	output logic [15:0] drop_fraction,
	output logic [63:0] one_way_delay_ns,
	output logic [39:0] data_rate,
	output logic        rate_invalid,
	output logic [47:0] next_timeout_ns,
	output logic        timeout_valid,
	output logic [15:0] stale_count,
	output logic [15:0] skip_count
);

	logic [15:0] gap_tol_q;
	logic accept, jq_push, jq_pop, jq_full, jq_empty, out_valid;
	ptrs_pkg::job_t job_in, job_out;
	ptrs_pkg::result_t res;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, gap_tol_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gap_tol_q <= ptrs_pkg::GAP_TOL_RST;
		else if (psel && penable && pwrite && pready && paddr == 2'd0)
			gap_tol_q <= pwdata[15:0];
	end

	assign full = jq_full;
	assign accept = push && !jq_full;

	ptrs_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.event_kind    (event_kind),
		.seq_number    (seq_number),
		.packet_index  (packet_index),
		.train_length  (train_length),
		.packet_length (packet_length),
		.send_time_ns  (send_time_ns),
		.recv_time_ns  (recv_time_ns),
		.gap_tol       (gap_tol_q),
		.job_push      (jq_push),
		.job           (job_in)
	);

	ptrs_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.wdata  (job_in),
		.pop    (jq_pop),
		.rdata  (job_out),
		.full   (jq_full),
		.empty  (jq_empty)
	);

	ptrs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.jq_empty  (jq_empty),
		.jq_data   (job_out),
		.jq_pop    (jq_pop),
		.pop       (pop),
		.out_valid (out_valid),
		.result    (res)
	);

	assign empty = !out_valid;
	assign close_cause = res.close_cause;
	assign train_seq = res.train_seq;
	assign drop_fraction = res.drop_fraction;
	assign one_way_delay_ns = res.one_way_delay_ns;
	assign data_rate = res.data_rate;
	assign rate_invalid = res.rate_invalid;
	assign next_timeout_ns = res.next_timeout_ns;
	assign timeout_valid = res.timeout_valid;
	assign stale_count = res.stale_count;
	assign skip_count = res.skip_count;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(jq_push && jq_full && !jq_pop))
		else $error("job queue overflow");
	a_rate_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && rate_invalid) |-> (data_rate == ptrs_pkg::RATE_MAX && !timeout_valid))
		else $error("invalid rate not saturated");
	a_tmo_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !timeout_valid) |-> (next_timeout_ns == '0))
		else $error("timeout value without valid");
	a_tmo_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && timeout_valid) |-> close_cause)
		else $error("timeout on packet close");

endmodule
